[design/cda_pkg.sv]
// Shared types, constants and calendar helper functions for the calendar date adder.
package cda_pkg;

   // Field widths
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int AMOUNT_W = 16;
   localparam int ACC_W    = 17;
   localparam int PROD_W   = 33;

   // Defaults and reset date
   localparam int                  DEFAULT_MAX_YEAR = 9999;
   localparam logic [YEAR_W-1:0]   RESET_YEAR       = 14'd2020;
   localparam logic [MONTH_W-1:0]  RESET_MONTH      = 4'd12;
   localparam logic [DAY_W-1:0]    RESET_DAY        = 5'd2;

   localparam logic [MONTH_W-1:0]  FIRST_MONTH      = 4'd1;
   localparam logic [MONTH_W-1:0]  MONTHS_PER_YEAR  = 4'd12;
   localparam logic [DAY_W-1:0]    FIRST_DAY        = 5'd1;
   localparam logic [DAY_W-1:0]    LAST_DAY         = 5'd31;

   // Divide by twelve: floor(t / 12) == (t * 43691) >> 19 for t below 2^17
   localparam logic [15:0]         RECIP12          = 16'd43691;
   localparam int                  QUOT_LSB         = 19;
   localparam int                  QUOT_W           = PROD_W - QUOT_LSB;

   // Divisibility by 25: y * inv(25) mod 2^14 falls at or below 16383 / 25
   localparam logic [YEAR_W-1:0]   INV25            = 14'd7209;
   localparam logic [YEAR_W-1:0]   DIV25_LIMIT      = 14'd655;

   typedef enum logic [1:0] {
      OP_LOAD       = 2'd0,
      OP_ADD_DAYS   = 2'd1,
      OP_ADD_MONTHS = 2'd2,
      OP_ADD_YEARS  = 2'd3
   } cda_op_type;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [YEAR_W-1:0]   load_year;
      logic [MONTH_W-1:0]  load_month;
      logic [DAY_W-1:0]    load_day;
      logic [AMOUNT_W-1:0] amount;
   } cda_req_type;

   typedef struct packed {
      logic [YEAR_W-1:0]   cur_year;
      logic [MONTH_W-1:0]  cur_month;
      logic [DAY_W-1:0]    cur_day;
      logic                overflow;
   } cda_rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic walk;
      logic mul;
      logic apply;
      logic load_rsp;
   } cda_ctl_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic walk_done;
   } cda_sts_type;

   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [YEAR_W-1:0] p;
      logic              div25;
      p     = y * INV25;
      div25 = (p <= DIV25_LIMIT);
      return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m) inside
         4'd2: begin
            len = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

endpackage

[design/cda_datapath.sv]
// Date registers, month walk, divide-by-twelve and result register.
module cda_datapath
   import cda_pkg::*;
#(
   parameter int MAX_YEAR = DEFAULT_MAX_YEAR
) (
   input  logic        clock,
   input  logic        reset,
   input  cda_ctl_type ctl,
   output cda_sts_type sts,
   input  cda_req_type req,
   output cda_rsp_type rsp
);

   localparam logic [ACC_W-1:0]  MaxAcc  = ACC_W'(MAX_YEAR);
   localparam logic [YEAR_W-1:0] MaxYear = YEAR_W'(MAX_YEAR);

   logic [YEAR_W-1:0]   year_ff,  year_in;
   logic [MONTH_W-1:0]  month_ff, month_in;
   logic [DAY_W-1:0]    day_ff,   day_in;
   logic                ovf_ff,   ovf_in;
   logic                leap_ff,  leap_in;
   logic [1:0]          cmd_ff,   cmd_in;
   logic [YEAR_W-1:0]   ly_ff,    ly_in;
   logic [MONTH_W-1:0]  lm_ff,    lm_in;
   logic [DAY_W-1:0]    ld_ff,    ld_in;
   logic [ACC_W-1:0]    acc_ff,   acc_in;
   logic [PROD_W-1:0]   prod_ff,  prod_in;
   cda_rsp_type         rsp_ff,   rsp_in;

   logic [DAY_W-1:0]    month_len;
   logic                fits;
   logic                last_month;
   logic                walk_sat;
   logic [ACC_W-1:0]    year_inc;
   logic [QUOT_W-1:0]   quot;
   logic [ACC_W-1:0]    quot12;
   logic [ACC_W-1:0]    rmd;
   logic [ACC_W-1:0]    month_year;
   logic [MONTH_W-1:0]  lm_clamp;
   logic [DAY_W-1:0]    ld_clamp;

   assign month_len  = month_days(leap_ff, month_ff);
   assign fits       = (acc_ff <= {{(ACC_W-DAY_W){1'b0}}, month_len});
   assign last_month = (month_ff >= MONTHS_PER_YEAR);
   assign year_inc   = {{(ACC_W-YEAR_W){1'b0}}, year_ff} + ACC_W'(1);
   assign walk_sat   = (year_inc > MaxAcc);
   assign sts.walk_done = fits || (last_month && walk_sat);

   assign quot       = prod_ff[PROD_W-1:QUOT_LSB];
   assign quot12     = ACC_W'({quot, 3'b000}) + ACC_W'({quot, 2'b00});
   assign rmd        = acc_ff - quot12;
   assign month_year = {{(ACC_W-YEAR_W){1'b0}}, year_ff} + ACC_W'(quot);

   assign lm_clamp = (lm_ff == 4'd0)            ? FIRST_MONTH :
                     (lm_ff > MONTHS_PER_YEAR)  ? MONTHS_PER_YEAR : lm_ff;
   assign ld_clamp = (ld_ff == 5'd0) ? FIRST_DAY : ld_ff;

   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      ovf_in   = ovf_ff;
      cmd_in   = cmd_ff;
      ly_in    = ly_ff;
      lm_in    = lm_ff;
      ld_in    = ld_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      rsp_in   = rsp_ff;
      leap_in  = is_leap(year_ff);

      if (ctl.capture) begin
         ovf_in = 1'b0;
         cmd_in = req.cmd;
         ly_in  = req.load_year;
         lm_in  = req.load_month;
         ld_in  = req.load_day;
         case (req.cmd)
            OP_ADD_DAYS: begin
               acc_in = {{(ACC_W-DAY_W){1'b0}}, day_ff} + {1'b0, req.amount};
            end
            OP_ADD_MONTHS: begin
               acc_in = {{(ACC_W-MONTH_W){1'b0}}, month_ff} - ACC_W'(1)
                        + {1'b0, req.amount};
            end
            default: begin
               acc_in = {{(ACC_W-YEAR_W){1'b0}}, year_ff} + {1'b0, req.amount};
            end
         endcase
      end

      if (ctl.mul) begin
         prod_in = acc_ff * RECIP12;
      end

      if (ctl.walk) begin
         if (fits) begin
            day_in = acc_ff[DAY_W-1:0];
         end else begin
            acc_in = acc_ff - {{(ACC_W-DAY_W){1'b0}}, month_len};
            if (last_month) begin
               if (walk_sat) begin
                  year_in  = MaxYear;
                  month_in = MONTHS_PER_YEAR;
                  day_in   = LAST_DAY;
                  ovf_in   = 1'b1;
               end else begin
                  year_in  = year_inc[YEAR_W-1:0];
                  month_in = FIRST_MONTH;
               end
            end else begin
               month_in = month_ff + 4'd1;
            end
         end
      end

      if (ctl.apply) begin
         unique case (cmd_ff)
            OP_LOAD: begin
               month_in = lm_clamp;
               day_in   = ld_clamp;
               if (ly_ff > MaxYear) begin
                  year_in = MaxYear;
                  ovf_in  = 1'b1;
               end else begin
                  year_in = ly_ff;
               end
            end
            OP_ADD_MONTHS: begin
               if (month_year > MaxAcc) begin
                  year_in  = MaxYear;
                  month_in = MONTHS_PER_YEAR;
                  day_in   = LAST_DAY;
                  ovf_in   = 1'b1;
               end else begin
                  year_in  = month_year[YEAR_W-1:0];
                  month_in = rmd[MONTH_W-1:0] + 4'd1;
               end
            end
            OP_ADD_YEARS: begin
               if (acc_ff > MaxAcc) begin
                  year_in  = MaxYear;
                  month_in = MONTHS_PER_YEAR;
                  day_in   = LAST_DAY;
                  ovf_in   = 1'b1;
               end else begin
                  year_in = acc_ff[YEAR_W-1:0];
               end
            end
            OP_ADD_DAYS: begin
               year_in = year_ff;
            end
         endcase
      end

      if (ctl.load_rsp) begin
         rsp_in.cur_year  = year_ff;
         rsp_in.cur_month = month_ff;
         rsp_in.cur_day   = day_ff;
         rsp_in.overflow  = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff  <= RESET_YEAR;
         month_ff <= RESET_MONTH;
         day_ff   <= RESET_DAY;
         ovf_ff   <= 1'b0;
         leap_ff  <= is_leap(RESET_YEAR);
      end else begin
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         ovf_ff   <= ovf_in;
         leap_ff  <= leap_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      ly_ff   <= ly_in;
      lm_ff   <= lm_in;
      ld_ff   <= ld_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

[design/cda_ctrl.sv]
// Command sequencer and result-valid flag for the calendar date adder.
module cda_ctrl
   import cda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_cmd,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output cda_ctl_type ctl,
   input  cda_sts_type sts
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_WALK  = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_APPLY = 5'b01000,
      ST_DONE  = 5'b10000
   } cda_state_type;

   cda_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               unique case (req_cmd) inside
                  OP_ADD_DAYS: begin
                     state_in = ST_WALK;
                  end
                  OP_ADD_MONTHS: begin
                     state_in = ST_MUL;
                  end
                  OP_LOAD, OP_ADD_YEARS: begin
                     state_in = ST_APPLY;
                  end
               endcase
            end
         end
         ST_WALK: begin
            ctl.walk = 1'b1;
            if (sts.walk_done) begin
               state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            ctl.mul  = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            ctl.apply = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               ctl.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[design/calendar_date_adder.sv]
// Sequence from accept to result valid: load and add-years go through apply and done,
// add-months through multiply, apply and done, add-days through the month walk and done.
// Flow: one command in flight; the next transfer can be taken the cycle after the result
// is registered, so add-days sets the rate through its one-month-per-cycle walk.
// Reset: synchronous, active high; date returns to 2020-12-02 and the result slot empties.
// Top level of the calendar date adder: sequencer plus date datapath.
module calendar_date_adder
   import cda_pkg::*;
#(
   parameter int MAX_YEAR = DEFAULT_MAX_YEAR
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  cda_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output cda_rsp_type rsp_data
);

   // Command bundle from the sequencer and walk status back from the datapath
   cda_ctl_type ctl;
   cda_sts_type sts;

   // Sequencer: capture a transfer, then walk months, divide then apply, or apply in one step,
   // and finally park the date in the result register once the slot is free.
   cda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   // Datapath: the date registers, the month walker, the divide-by-twelve multiplier
   // and the result register that holds the reported date while the next command runs.
   cda_datapath #(
      .MAX_YEAR (MAX_YEAR)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .sts   (sts),
      .req   (req_data),
      .rsp   (rsp_data)
   );

   // Hold off new transfers while a command is being worked.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while a command is still in progress");

   // Loading the result register must raise result valid.
   a_rsp_after_load: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |=> rsp_valid)
      else $error("result loaded but not presented");

   // Advance the walk until the datapath reports the walk done.
   a_walk_continues: assert property (@(posedge clock) disable iff (reset)
      (ctl.walk && !sts.walk_done) |=> ctl.walk)
      else $error("month walk dropped before completion");

   // Reported month stays within one to twelve and the reported day is never zero.
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.cur_month >= FIRST_MONTH) &&
                    (rsp_data.cur_month <= MONTHS_PER_YEAR) &&
                    (rsp_data.cur_day >= FIRST_DAY))
      else $error("result month or day out of range");

   // Overflow always leaves the year pinned at the limit.
   a_ovf_year: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overflow) |-> (rsp_data.cur_year == YEAR_W'(MAX_YEAR)))
      else $error("overflow reported without saturated year");

endmodule

[tb/sv/cda_date_checker.sv]
// Date scoreboard for the calendar date adder: predicts every response from the request transfers.
module cda_date_checker
   import cda_pkg::*;
#(
   parameter int MAX_YEAR = DEFAULT_MAX_YEAR
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  cda_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  cda_rsp_type rsp_data,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [YEAR_W-1:0]  year_q;
   logic [MONTH_W-1:0] month_q;
   logic [DAY_W-1:0]   day_q;
   cda_rsp_type        pending_dates[$];
   int                 errors;

   function automatic bit leap_year(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
      int unsigned len;
      case (m) inside
         2: begin
            len = leap_year(y) ? 29 : 28;
         end
         4, 6, 9, 11: begin
            len = 30;
         end
         default: begin
            len = 31;
         end
      endcase
      return len;
   endfunction

   // Apply one command to the held date and return the date reported after it.
   function automatic cda_rsp_type step_calendar(input cda_req_type item);
      int unsigned y;
      int unsigned m;
      int unsigned d;
      int unsigned amt;
      int unsigned rem;
      int unsigned total;
      bit          ovf;
      bit          pin;
      cda_rsp_type res;
      y   = year_q;
      m   = month_q;
      d   = day_q;
      amt = item.amount;
      ovf = 1'b0;
      pin = 1'b0;
      case (cda_op_type'(item.cmd))
         OP_LOAD: begin
            y = item.load_year;
            m = item.load_month;
            d = item.load_day;
            if (m < 1) m = 1;
            if (m > 12) m = 12;
            if (d < 1) d = 1;
            if (y > MAX_YEAR) begin
               y   = MAX_YEAR;
               ovf = 1'b1;
            end
         end
         OP_ADD_DAYS: begin
            rem = d + amt;
            while (!pin && rem > days_in_month(y, m)) begin
               rem = rem - days_in_month(y, m);
               if (m >= 12) begin
                  if (y + 1 > MAX_YEAR) begin
                     pin = 1'b1;
                  end else begin
                     y = y + 1;
                     m = 1;
                  end
               end else begin
                  m = m + 1;
               end
            end
            if (!pin) d = rem;
         end
         OP_ADD_MONTHS: begin
            total = m - 1 + amt;
            if (y + total / 12 > MAX_YEAR) begin
               pin = 1'b1;
            end else begin
               y = y + total / 12;
               m = total % 12 + 1;
            end
         end
         default: begin
            if (y + amt > MAX_YEAR) pin = 1'b1;
            else y = y + amt;
         end
      endcase
      // saturation pins the date to the last day of the last year
      if (pin) begin
         y   = MAX_YEAR;
         m   = 12;
         d   = 31;
         ovf = 1'b1;
      end
      year_q        = y[YEAR_W-1:0];
      month_q       = m[MONTH_W-1:0];
      day_q         = d[DAY_W-1:0];
      res.cur_year  = year_q;
      res.cur_month = month_q;
      res.cur_day   = day_q;
      res.overflow  = ovf;
      return res;
   endfunction

   always @(posedge clock) begin
      cda_rsp_type want;
      if (reset) begin
         year_q  = RESET_YEAR;
         month_q = RESET_MONTH;
         day_q   = RESET_DAY;
         pending_dates.delete();
      end else begin
         // retire the response first so it can never match a request taken this edge
         if (rsp_valid && rsp_ready) begin
            if (pending_dates.size() == 0) begin
               $display("%0t: response %0d-%0d-%0d ovf %0b with none expected", $time,
                        rsp_data.cur_year, rsp_data.cur_month, rsp_data.cur_day,
                        rsp_data.overflow);
               errors = errors + 1;
            end else begin
               want = pending_dates.pop_front();
               if (rsp_data.cur_year !== want.cur_year || rsp_data.cur_month !== want.cur_month
                   || rsp_data.cur_day !== want.cur_day
                   || rsp_data.overflow !== want.overflow) begin
                  $display("%0t: expected %0d-%0d-%0d ovf %0b, got %0d-%0d-%0d ovf %0b", $time,
                           want.cur_year, want.cur_month, want.cur_day, want.overflow,
                           rsp_data.cur_year, rsp_data.cur_month, rsp_data.cur_day,
                           rsp_data.overflow);
                  errors = errors + 1;
               end
            end
         end
         if (req_valid && req_ready) pending_dates.push_back(step_calendar(req_data));
      end
      pending    <= pending_dates.size();
      fail_count <= errors;
   end

endmodule

[tb/sv/tb_calendar_date_adder.sv]
// Testbench top for the calendar date adder: clock, reset, request and response traffic, verdict.
module tb_calendar_date_adder
   import cda_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOP_YEAR     = DEFAULT_MAX_YEAR;
   localparam int RANDOM_ITEMS = 250;
   // worst case is a month walk for a 65535-day add on each item plus stalls; take it several times over
   localparam int LIMIT_CYCLES = 3000000;
   // extra wait for stray responses once every predicted date is seen; allow a good margin
   localparam int DRAIN_CYCLES = 20;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   cda_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   cda_rsp_type rsp_data;
   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   int          hold_cycles = 0;
   // when set, neither side idles: back-to-back transfers
   bit          steady      = 1'b0;

   calendar_date_adder #(
      .MAX_YEAR (TOP_YEAR)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   cda_date_checker #(
      .MAX_YEAR (TOP_YEAR)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop in case the block hangs or a handshake never completes.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("tb_calendar_date_adder failed");
         $finish;
      end
   end

   // Idle length: mostly none, often short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady) return 0;
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Response side: hold ready low for random stretches, except in steady phases.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         hold_cycles = 0;
      end else if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) hold_cycles = pick_gap();
      end
   end

   function automatic cda_req_type make_req(input cda_op_type op, input int unsigned y,
                                            input int unsigned m, input int unsigned d,
                                            input int unsigned amt);
      cda_req_type item;
      item.cmd        = op;
      item.load_year  = y[YEAR_W-1:0];
      item.load_month = m[MONTH_W-1:0];
      item.load_day   = d[DAY_W-1:0];
      item.amount     = amt[AMOUNT_W-1:0];
      return item;
   endfunction

   // Random command. Loads are mostly well-formed dates so the adds walk real calendars;
   // the rest fill every field bit at random. Large day counts stay rare since the walk
   // runs longer for every month it crosses.
   function automatic cda_req_type random_req();
      int          roll;
      int          sub;
      int unsigned y;
      int unsigned amt;
      cda_req_type item;
      item = '0;
      roll = $urandom_range(0, 99);
      sub  = $urandom_range(0, 99);
      if (roll < 25) begin
         if (sub < 15) begin
            item.cmd        = OP_LOAD;
            item.load_year  = YEAR_W'($urandom);
            item.load_month = MONTH_W'($urandom);
            item.load_day   = DAY_W'($urandom);
            item.amount     = AMOUNT_W'($urandom);
         end else begin
            if (sub < 55) y = $urandom_range(1800, 2500);
            else if (sub < 75) y = $urandom_range(0, TOP_YEAR);
            else if (sub < 90) y = $urandom_range(TOP_YEAR - 100, TOP_YEAR);
            else y = $urandom_range(0, 200);
            item = make_req(OP_LOAD, y, $urandom_range(1, 12), $urandom_range(1, 31), 0);
         end
      end else if (roll < 65) begin
         if (sub < 70) amt = $urandom_range(0, 400);
         else if (sub < 95) amt = $urandom_range(0, 4000);
         else amt = $urandom_range(0, 65535);
         item = make_req(OP_ADD_DAYS, $urandom, $urandom, $urandom, amt);
      end else if (roll < 82) begin
         if (sub < 60) amt = $urandom_range(0, 30);
         else amt = $urandom_range(0, 65535);
         item = make_req(OP_ADD_MONTHS, $urandom, $urandom, $urandom, amt);
      end else begin
         if (sub < 60) amt = $urandom_range(0, 50);
         else if (sub < 85) amt = $urandom_range(0, TOP_YEAR);
         else amt = $urandom_range(0, 65535);
         item = make_req(OP_ADD_YEARS, $urandom, $urandom, $urandom, amt);
      end
      return item;
   endfunction

   // Present one request and hold it until the transfer. Valid stays high across
   // back-to-back requests; it only drops when a gap is inserted.
   task automatic send_req(input cda_req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset date with a zero add: nothing moves.
      send_req(make_req(OP_ADD_DAYS, 0, 0, 0, 0));
      // Leap day in an ordinary leap year, then roll into March.
      send_req(make_req(OP_LOAD, 2024, 2, 28, 0));
      send_req(make_req(OP_ADD_DAYS, 0, 0, 0, 1));
      send_req(make_req(OP_ADD_DAYS, 0, 0, 0, 1));
      // Century years: 1900 has no leap day, 2000 does.
      send_req(make_req(OP_LOAD, 1900, 2, 28, 0));
      send_req(make_req(OP_ADD_DAYS, 0, 0, 0, 1));
      send_req(make_req(OP_LOAD, 2000, 2, 28, 0));
      send_req(make_req(OP_ADD_DAYS, 0, 0, 0, 1));
      // Zero month and zero day are clamped to one; year zero is a leap year.
      send_req(make_req(OP_LOAD, 0, 0, 0, 0));
      // Months above twelve clamp to December.
      send_req(make_req(OP_LOAD, 2023, 15, 31, 0));
      // Year field all ones saturates with overflow.
      send_req(make_req(OP_LOAD, 16383, 13, 31, 65535));
      // Day past the month end carries on the next day add: Feb 31 plus zero days.
      send_req(make_req(OP_LOAD, 2021, 2, 31, 0));
      send_req(make_req(OP_ADD_DAYS, 0, 0, 0, 0));
      send_req(make_req(OP_LOAD, 2020, 2, 31, 0));
      send_req(make_req(OP_ADD_DAYS, 0, 0, 0, 0));
      // Month add keeps the day even where the month is shorter.
      send_req(make_req(OP_LOAD, 2021, 1, 31, 0));
      send_req(make_req(OP_ADD_MONTHS, 0, 0, 0, 1));
      // Year rollover on a day add, then the largest day add from the first of January 2100.
      send_req(make_req(OP_LOAD, 2099, 12, 31, 0));
      send_req(make_req(OP_ADD_DAYS, 0, 0, 0, 1));
      send_req(make_req(OP_ADD_DAYS, 0, 0, 0, 65535));
      // Zero month and year adds.
      send_req(make_req(OP_ADD_MONTHS, 0, 0, 0, 0));
      send_req(make_req(OP_ADD_YEARS, 0, 0, 0, 0));
      // Saturation from each add near the top year.
      send_req(make_req(OP_LOAD, TOP_YEAR, 12, 31, 0));
      send_req(make_req(OP_ADD_DAYS, 0, 0, 0, 1));
      send_req(make_req(OP_LOAD, TOP_YEAR - 1, 11, 15, 0));
      send_req(make_req(OP_ADD_MONTHS, 0, 0, 0, 2));
      send_req(make_req(OP_ADD_MONTHS, 0, 0, 0, 65535));
      send_req(make_req(OP_LOAD, TOP_YEAR, 6, 15, 0));
      send_req(make_req(OP_ADD_YEARS, 0, 0, 0, 1));

      // Random traffic, with a no-idle stretch in every 64 transfers.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = (i % 64) >= 48;
         send_req(random_req());
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      // Drain: wait for every predicted date, then a little longer for stray responses.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_calendar_date_adder passed");
      end else begin
         $display("tb_calendar_date_adder failed");
      end
      $finish;
   end

endmodule
